[src/gdfs_pkg.sv]
// Shared types, codes and defaults of the grid depth-first search block.
package gdfs_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  localparam int COORD_W  = 6;
  localparam int SIZE_W   = 7;
  localparam int CNT_W    = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [SIZE_W-1:0]  GRID_WIDTH_RST  = 7'd64;
  localparam logic [SIZE_W-1:0]  GRID_HEIGHT_RST = 7'd64;
  localparam logic [COORD_W-1:0] START_X_RST     = 6'd0;
  localparam logic [COORD_W-1:0] START_Y_RST     = 6'd0;
  localparam logic [COORD_W-1:0] END_X_RST       = 6'd63;
  localparam logic [COORD_W-1:0] END_Y_RST       = 6'd63;

  // parent direction codes as read back
  localparam logic [1:0] PAR_UP    = 2'd0;
  localparam logic [1:0] PAR_DOWN  = 2'd1;
  localparam logic [1:0] PAR_LEFT  = 2'd2;
  localparam logic [1:0] PAR_RIGHT = 2'd3;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_BEGIN = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STAT_ACK      = 3'd0,
    STAT_PUSHED   = 3'd1,
    STAT_POPPED   = 3'd2,
    STAT_GOAL     = 3'd3,
    STAT_EMPTY    = 3'd4,
    STAT_FINISHED = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_START_X     = 3'd2,
    CFG_START_Y     = 3'd3,
    CFG_END_X       = 3'd4,
    CFG_END_Y       = 3'd5
  } cfg_reg_t;

  // neighbour probe order
  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_RD,
    S_TOP,
    S_PROBE,
    S_CHECK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       wall;
    logic       visited;
    logic [1:0] parent;
  } cell_t;

  typedef struct packed {
    logic wall;
    logic visited;
    logic parent;
  } cell_we_t;

  typedef struct packed {
    status_t            status;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [COORD_W-1:0] next_x;
    logic [COORD_W-1:0] next_y;
    logic               cell_wall;
    logic               cell_visited;
    logic [1:0]         parent_dir;
  } result_t;

  // direction of the parent seen from a neighbour reached by this move
  function automatic logic [1:0] par_of(input dir_t d);
    logic [1:0] p;
    unique case (d)
      DIR_DOWN:  p = PAR_UP;
      DIR_UP:    p = PAR_DOWN;
      DIR_RIGHT: p = PAR_LEFT;
      DIR_LEFT:  p = PAR_RIGHT;
      default:   p = PAR_UP;
    endcase
    return p;
  endfunction

endpackage

[src/grid_depth_first_search.sv]
// Grid depth-first search: cell and stack memories with a step sequencer.
// From the accepting edge to the result beat: a write goes straight to the output, a read passes
//   S_RD, a step passes S_TOP, then S_PROBE and S_CHECK per neighbour probed (1..4), or goes
//   straight out when the search is over or the stack is empty; a begin sweeps S_CLR over all cells.
//   A new item waits until the last result is loaded; each probe is a cell read, then a check.
// Reset: synchronous, active low; then a sweep over all MAX_COLS*MAX_ROWS cells clears walls
//   and visited bits with in_stall high. Configuration writes are taken at all times.
module grid_depth_first_search
  import gdfs_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input item channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_action,
  input  logic [COORD_W-1:0]   in_cell_x,
  input  logic [COORD_W-1:0]   in_cell_y,
  input  logic                 in_wall_in,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [COORD_W-1:0]   out_cur_x,
  output logic [COORD_W-1:0]   out_cur_y,
  output logic [COORD_W-1:0]   out_next_x,
  output logic [COORD_W-1:0]   out_next_y,
  output logic [CNT_W-1:0]     out_explored_count,
  output logic                 out_cell_wall,
  output logic                 out_cell_visited,
  output logic [1:0]           out_parent_dir,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  // Coordinate widths: CW/RW index the store, XW/YW hold one step past either edge,
  // WW/HW compare against the configured size.
  localparam int CW     = $clog2(MAX_COLS);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int XW     = CW + 1;
  localparam int YW     = RW + 1;
  localparam int WW     = (XW > SIZE_W) ? XW : SIZE_W;
  localparam int HW     = (YW > SIZE_W) ? YW : SIZE_W;
  localparam int NCELLS = MAX_COLS * MAX_ROWS;
  localparam int AW     = $clog2(NCELLS);
  localparam int SPW    = AW + 1;

  localparam logic [WW-1:0]  COLS_W   = WW'(MAX_COLS);
  localparam logic [HW-1:0]  ROWS_H   = HW'(MAX_ROWS);
  localparam logic [AW-1:0]  COLS_A   = AW'(MAX_COLS);
  localparam logic [AW-1:0]  LAST_A   = AW'(NCELLS - 1);
  localparam logic [SPW-1:0] NCELLS_S = SPW'(NCELLS);

  typedef struct packed {
    logic [RW-1:0] y;
    logic [CW-1:0] x;
  } stk_ent_t;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] y,
                                               input logic [CW-1:0] x);
    return AW'(y) * COLS_A + AW'(x);
  endfunction

  // ---------------------------------------------------------------------------
  // Storage. The cell memory holds wall, visited and parent per cell with one
  // write port (per-field enables) and one registered read port. The stack
  // memory holds pushed cells as (y, x) pairs.
  // ---------------------------------------------------------------------------
  cell_t    cell_mem [NCELLS];
  stk_ent_t stk_mem  [NCELLS];

  cell_we_t      cm_we;
  logic [AW-1:0] cm_waddr;
  cell_t         cm_wdata;
  logic [AW-1:0] cm_raddr;
  cell_t         cm_rdata_r;

  logic          stk_we;
  logic [AW-1:0] stk_waddr;
  stk_ent_t      stk_wdata;
  logic [AW-1:0] stk_raddr;
  stk_ent_t      stk_rdata_r;

  always_ff @(posedge clk) begin
    if (cm_we.wall) begin
      cell_mem[cm_waddr].wall <= cm_wdata.wall;
    end
    if (cm_we.visited) begin
      cell_mem[cm_waddr].visited <= cm_wdata.visited;
    end
    if (cm_we.parent) begin
      cell_mem[cm_waddr].parent <= cm_wdata.parent;
    end
    cm_rdata_r <= cell_mem[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_r <= stk_mem[stk_raddr];
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]  grid_width_r, grid_height_r;
  logic [COORD_W-1:0] start_x_r, start_y_r, end_x_r, end_y_r;

  logic [SPW-1:0]   sp_r, sp_nxt;
  logic [CNT_W-1:0] explored_r, explored_nxt;
  logic             goal_r, goal_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  dir_t             k_r, k_nxt;

  result_t          res_r, res_nxt;
  stk_ent_t         top_r, top_nxt;
  logic [AW-1:0]    top_addr_r, top_addr_nxt;
  stk_ent_t         nb_r, nb_nxt;
  logic [AW-1:0]    nb_addr_r, nb_addr_nxt;
  logic             nb_ok_r, nb_ok_nxt;
  logic             rd_ok_r, rd_ok_nxt;

  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r, out_res_nxt;
  logic [CNT_W-1:0] out_explored_r, out_explored_nxt;

  // ---------------------------------------------------------------------------
  // Shared decode
  // ---------------------------------------------------------------------------
  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;
  logic           accept;
  logic           out_free;
  logic           in_ok;
  logic [AW-1:0]  in_addr;
  logic           start_ok;
  logic [SPW-1:0] sp_m1;
  logic           sp_empty;
  logic           sp_full;
  logic           clr_last;
  logic [XW-1:0]  nb_xw;
  logic [YW-1:0]  nb_yw;
  logic           nb_ok;
  stk_ent_t       nb_cell;
  logic           usable;
  logic           at_end;

  // columns and rows in use are capped at the store size
  assign eff_w = (WW'(grid_width_r) > COLS_W) ? COLS_W : WW'(grid_width_r);
  assign eff_h = (HW'(grid_height_r) > ROWS_H) ? ROWS_H : HW'(grid_height_r);

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_ok    = (WW'(in_cell_x) < COLS_W) && (HW'(in_cell_y) < ROWS_H);
  assign in_addr  = cell_addr(RW'(in_cell_y), CW'(in_cell_x));
  assign start_ok = (WW'(start_x_r) < eff_w) && (HW'(start_y_r) < eff_h);
  assign sp_m1    = sp_r - SPW'(1);
  assign sp_empty = (sp_r == '0);
  assign sp_full  = (sp_r >= NCELLS_S);
  assign clr_last = (clr_r == LAST_A);

  // Neighbour under test. One step off the low edge wraps to all ones, which is
  // never below the size in use, so a single compare per axis covers both edges.
  always_comb begin
    nb_xw = XW'(top_r.x);
    nb_yw = YW'(top_r.y);
    unique case (k_r)
      DIR_DOWN:  nb_yw = YW'(top_r.y) + YW'(1);
      DIR_UP:    nb_yw = YW'(top_r.y) - YW'(1);
      DIR_RIGHT: nb_xw = XW'(top_r.x) + XW'(1);
      DIR_LEFT:  nb_xw = XW'(top_r.x) - XW'(1);
      default:   nb_xw = XW'(top_r.x);
    endcase
  end

  assign nb_ok     = (WW'(nb_xw) < eff_w) && (HW'(nb_yw) < eff_h);
  assign nb_cell.x = nb_xw[CW-1:0];
  assign nb_cell.y = nb_yw[RW-1:0];

  // cell memory data for the probe issued last cycle
  assign usable = nb_ok_r && !cm_rdata_r.wall && !cm_rdata_r.visited;
  assign at_end = (WW'(nb_r.x) == WW'(end_x_r)) && (HW'(nb_r.y) == HW'(end_y_r));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (action_t'(in_action))
            ACT_WRITE: state_nxt = S_EMIT;
            ACT_BEGIN: state_nxt = S_CLR;
            ACT_STEP:  state_nxt = (goal_r || sp_empty) ? S_EMIT : S_TOP;
            ACT_READ:  state_nxt = S_RD;
            default:   state_nxt = S_EMIT;
          endcase
        end
      end
      S_CLR: begin
        if (clr_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_RD:    state_nxt = S_EMIT;
      S_TOP:   state_nxt = S_PROBE;
      S_PROBE: state_nxt = S_CHECK;
      S_CHECK: begin
        if (usable || (k_r == DIR_LEFT)) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and memory controls
  // ---------------------------------------------------------------------------
  always_comb begin
    cm_we        = '0;
    cm_waddr     = clr_r;
    cm_wdata     = '0;
    cm_raddr     = in_addr;
    stk_we       = 1'b0;
    stk_waddr    = sp_r[AW-1:0];
    stk_wdata    = nb_r;
    stk_raddr    = sp_m1[AW-1:0];

    sp_nxt       = sp_r;
    explored_nxt = explored_r;
    goal_nxt     = goal_r;
    clr_nxt      = '0;
    k_nxt        = k_r;
    res_nxt      = res_r;
    top_nxt      = top_r;
    top_addr_nxt = top_addr_r;
    nb_nxt       = nb_r;
    nb_addr_nxt  = nb_addr_r;
    nb_ok_nxt    = nb_ok_r;
    rd_ok_nxt    = rd_ok_r;

    unique case (state_r)
      S_INIT: begin
        // clear walls and visited bits, one entry a cycle
        cm_we.wall    = 1'b1;
        cm_we.visited = 1'b1;
        cm_waddr      = clr_r;
        clr_nxt       = clr_last ? '0 : clr_r + AW'(1);
      end

      S_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          unique case (action_t'(in_action))
            ACT_WRITE: begin
              res_nxt.status = STAT_ACK;
              res_nxt.cur_x  = in_cell_x;
              res_nxt.cur_y  = in_cell_y;
              cm_we.wall     = in_ok;
              cm_waddr       = in_addr;
              cm_wdata.wall  = in_wall_in;
            end
            ACT_BEGIN: begin
              // restart the search and seed the stack with the start cell when it lies inside the grid
              res_nxt.status = STAT_ACK;
              res_nxt.cur_x  = start_x_r;
              res_nxt.cur_y  = start_y_r;
              explored_nxt   = '0;
              goal_nxt       = 1'b0;
              stk_we         = start_ok;
              stk_waddr      = '0;
              stk_wdata.x    = CW'(start_x_r);
              stk_wdata.y    = RW'(start_y_r);
              sp_nxt         = start_ok ? SPW'(1) : '0;
            end
            ACT_STEP: begin
              if (goal_r) begin
                res_nxt.status = STAT_FINISHED;
              end else if (sp_empty) begin
                res_nxt.status = STAT_EMPTY;
              end else begin
                // stack top read is issued here
                k_nxt = DIR_DOWN;
              end
            end
            ACT_READ: begin
              res_nxt.status = STAT_ACK;
              res_nxt.cur_x  = in_cell_x;
              res_nxt.cur_y  = in_cell_y;
              cm_raddr       = in_addr;
              rd_ok_nxt      = in_ok;
            end
            default: res_nxt.status = STAT_ACK;
          endcase
        end
      end

      S_CLR: begin
        // wipe visited bits only; walls and parents survive a restart
        cm_we.visited = 1'b1;
        cm_waddr      = clr_r;
        clr_nxt       = clr_last ? '0 : clr_r + AW'(1);
      end

      S_RD: begin
        res_nxt.cell_wall    = rd_ok_r && cm_rdata_r.wall;
        res_nxt.cell_visited = rd_ok_r && cm_rdata_r.visited;
        res_nxt.parent_dir   = rd_ok_r ? cm_rdata_r.parent : '0;
      end

      S_TOP: begin
        top_nxt       = stk_rdata_r;
        top_addr_nxt  = cell_addr(stk_rdata_r.y, stk_rdata_r.x);
        res_nxt.cur_x = COORD_W'(stk_rdata_r.x);
        res_nxt.cur_y = COORD_W'(stk_rdata_r.y);
      end

      S_PROBE: begin
        // issue the neighbour read; on the first probe mark and count the top
        cm_raddr    = cell_addr(nb_cell.y, nb_cell.x);
        nb_nxt      = nb_cell;
        nb_addr_nxt = cell_addr(nb_cell.y, nb_cell.x);
        nb_ok_nxt   = nb_ok;
        if (k_r == DIR_DOWN) begin
          cm_we.visited    = 1'b1;
          cm_waddr         = top_addr_r;
          cm_wdata.visited = 1'b1;
          if (explored_r != CNT_MAX) begin
            explored_nxt = explored_r + CNT_W'(1);
          end
        end
      end

      S_CHECK: begin
        if (usable) begin
          cm_we.parent    = 1'b1;
          cm_waddr        = nb_addr_r;
          cm_wdata.parent = par_of(k_r);
          res_nxt.next_x  = COORD_W'(nb_r.x);
          res_nxt.next_y  = COORD_W'(nb_r.y);
          if (at_end) begin
            goal_nxt       = 1'b1;
            res_nxt.status = STAT_GOAL;
          end else begin
            // drop the push when the stack is full
            res_nxt.status = STAT_PUSHED;
            stk_we         = !sp_full;
            stk_waddr      = sp_r[AW-1:0];
            stk_wdata      = nb_r;
            if (!sp_full) begin
              sp_nxt = sp_r + SPW'(1);
            end
          end
        end else if (k_r == DIR_LEFT) begin
          // dead end: pop the top
          res_nxt.status = STAT_POPPED;
          sp_nxt         = sp_m1;
        end else begin
          k_nxt = dir_t'(k_r + 2'd1);
        end
      end

      S_EMIT: begin
      end

      default: begin
      end
    endcase
  end

  // Output register: hold a stalled beat, load a new one when the slot frees.
  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_res_nxt      = out_res_r;
    out_explored_nxt = out_explored_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == S_EMIT) && out_free) begin
      out_valid_nxt    = 1'b1;
      out_res_nxt      = res_r;
      out_explored_nxt = explored_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      sp_r          <= '0;
      explored_r    <= '0;
      goal_r        <= 1'b0;
      clr_r         <= '0;
      k_r           <= DIR_DOWN;
      out_valid_r   <= 1'b0;
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      start_x_r     <= START_X_RST;
      start_y_r     <= START_Y_RST;
      end_x_r       <= END_X_RST;
      end_y_r       <= END_Y_RST;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      explored_r  <= explored_nxt;
      goal_r      <= goal_nxt;
      clr_r       <= clr_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
          CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
          CFG_START_X:     start_x_r     <= cfg_data[COORD_W-1:0];
          CFG_START_Y:     start_y_r     <= cfg_data[COORD_W-1:0];
          CFG_END_X:       end_x_r       <= cfg_data[COORD_W-1:0];
          CFG_END_Y:       end_y_r       <= cfg_data[COORD_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    res_r          <= res_nxt;
    top_r          <= top_nxt;
    top_addr_r     <= top_addr_nxt;
    nb_r           <= nb_nxt;
    nb_addr_r      <= nb_addr_nxt;
    nb_ok_r        <= nb_ok_nxt;
    rd_ok_r        <= rd_ok_nxt;
    out_res_r      <= out_res_nxt;
    out_explored_r <= out_explored_nxt;
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign in_stall           = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_cur_x          = out_res_r.cur_x;
  assign out_cur_y          = out_res_r.cur_y;
  assign out_next_x         = out_res_r.next_x;
  assign out_next_y         = out_res_r.next_y;
  assign out_explored_count = out_explored_r;
  assign out_cell_wall      = out_res_r.cell_wall;
  assign out_cell_visited   = out_res_r.cell_visited;
  assign out_parent_dir     = out_res_r.parent_dir;

endmodule

[src/gdfs_checker.sv]
// Port-level assertions for the grid depth-first search block, with its bind.
module gdfs_checker
  import gdfs_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_status,
  input logic [COORD_W-1:0] out_cur_x,
  input logic [COORD_W-1:0] out_cur_y,
  input logic [COORD_W-1:0] out_next_x,
  input logic [COORD_W-1:0] out_next_y,
  input logic [CNT_W-1:0]   out_explored_count,
  input logic               out_cell_wall,
  input logic               out_cell_visited,
  input logic [1:0]         out_parent_dir
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_cur_x) &&
      $stable(out_cur_y) && $stable(out_next_x) && $stable(out_next_y) &&
      $stable(out_explored_count) && $stable(out_parent_dir))
    else $error("stalled result beat changed");

  // one item at a time: an accepted beat closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on two consecutive edges");

  // cell bits come only with a write or read acknowledge
  a_cell_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_ACK) |->
      !out_cell_wall && !out_cell_visited && (out_parent_dir == 2'd0))
    else $error("cell bits reported on a non-read result");

  // a push, a goal or a pop follows a counted cell
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == STAT_PUSHED) || (out_status == STAT_GOAL) ||
      (out_status == STAT_POPPED)) |-> (out_explored_count != '0))
    else $error("step result with zero explored count");

  // no neighbour is named unless one was chosen
  a_next_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == STAT_ACK) || (out_status == STAT_POPPED) ||
      (out_status == STAT_EMPTY) || (out_status == STAT_FINISHED)) |->
      (out_next_x == '0) && (out_next_y == '0))
    else $error("neighbour reported without a choice");

endmodule

bind grid_depth_first_search gdfs_checker u_gdfs_checker (.*);
